>>> rtl/ifla_pkg.sv
package ifla_pkg;

   // Field widths
   localparam int WORD_W = 13;
   localparam int OFF_W  = 12;
   localparam int LEN_W  = 12;
   localparam int ACT_W  = 2;
   localparam int ST_W   = 2;

   // Heap geometry defaults
   localparam int HEAP_WORDS_DEF = 1024;
   localparam logic [OFF_W-1:0] HEAP_BYTES_RESET = 12'd4084;

   // Config port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_HEAP_BYTES = 1'b0;

   // Actions
   localparam logic [ACT_W-1:0] ACT_FORMAT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FREE     = 2'd2;
   localparam logic [ACT_W-1:0] ACT_COALESCE = 2'd3;

   // Result status
   localparam logic [ST_W-1:0] ST_OK           = 2'd0;
   localparam logic [ST_W-1:0] ST_NO_FIT       = 2'd1;
   localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd2;
   localparam logic [ST_W-1:0] ST_SENTINEL     = 2'd3;

   // Header word that closes the list
   localparam logic [WORD_W-1:0] SENTINEL_WORD = 13'd1;

   // Finished result handed from the engine to the output register
   typedef struct packed {
      logic             valid;
      logic [OFF_W-1:0] payload_offset;
      logic [ST_W-1:0]  status;
   } res_type;

   // Round (v + 4) up to a multiple of 8
   function automatic logic [WORD_W-1:0] round8_plus4(input logic [OFF_W-1:0] v);
      logic [WORD_W-1:0] sum;
      sum = {1'b0, v} + 13'd11;
      return {sum[WORD_W-1:3], 3'b000};
   endfunction

endpackage

>>> rtl/ifla_heap_ram.sv
module ifla_heap_ram #(
   parameter int DEPTH = ifla_pkg::HEAP_WORDS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [ifla_pkg::WORD_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [ifla_pkg::WORD_W-1:0] wr_data
);

   logic [ifla_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [ifla_pkg::WORD_W-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ifla_csr.sv
module ifla_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ifla_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ifla_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ifla_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic [ifla_pkg::OFF_W-1:0]      heap_bytes
);

   logic [ifla_pkg::OFF_W-1:0] heap_bytes_ff;
   logic [ifla_pkg::OFF_W-1:0] heap_bytes_in;
   logic                       hit;

   assign hit = (csr_paddr[2] == ifla_pkg::REG_HEAP_BYTES);

   // Write on the access phase
   always_comb begin
      heap_bytes_in = heap_bytes_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         heap_bytes_in = csr_pwdata[ifla_pkg::OFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= ifla_pkg::HEAP_BYTES_RESET;
      end else begin
         heap_bytes_ff <= heap_bytes_in;
      end
   end

   // Read back
   assign csr_prdata = hit ? {{(ifla_pkg::CSR_DATA_W - ifla_pkg::OFF_W){1'b0}}, heap_bytes_ff}
                           : '0;
   assign csr_pready = 1'b1;
   assign heap_bytes = heap_bytes_ff;

endmodule

>>> rtl/ifla_engine.sv
module ifla_engine #(
   parameter int HEAP_WORDS = ifla_pkg::HEAP_WORDS_DEF,
   localparam int IDX_W = $clog2(HEAP_WORDS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ifla_pkg::ACT_W-1:0]  req_action,
   input  logic [ifla_pkg::LEN_W-1:0]  req_length,
   input  logic [ifla_pkg::OFF_W-1:0]  req_address,
   input  logic [ifla_pkg::OFF_W-1:0]  heap_bytes,
   output ifla_pkg::res_type           res,
   input  logic                        res_take,
   output logic                        ram_rd_en,
   output logic [IDX_W-1:0]            ram_rd_addr,
   input  logic [ifla_pkg::WORD_W-1:0] ram_rd_data,
   output logic                        ram_wr_en,
   output logic [IDX_W-1:0]            ram_wr_addr,
   output logic [ifla_pkg::WORD_W-1:0] ram_wr_data
);

   localparam int WORD_W   = ifla_pkg::WORD_W;
   localparam int WALK_W   = ((IDX_W > 11) ? IDX_W : 11) + 1;
   localparam int BUD_W    = IDX_W + 1;
   localparam int FMT_W    = ((IDX_W + 1) > 11) ? (IDX_W + 1) : 11;
   localparam int HEAP_CAP = (HEAP_WORDS / 2) * 2;

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_FMT    = 4'd2;
   localparam logic [3:0] S_ALLOC  = 4'd3;
   localparam logic [3:0] S_SPLIT  = 4'd4;
   localparam logic [3:0] S_FREE   = 4'd5;
   localparam logic [3:0] S_CO_HDR = 4'd6;
   localparam logic [3:0] S_CO_NX  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]                  state_ff, state_in;
   logic [ifla_pkg::ACT_W-1:0]  act_ff, act_in;
   logic [WORD_W-1:0]           need_ff, need_in;
   logic [9:0]                  word_ff, word_in;
   logic [WALK_W-1:0]           idx_ff, idx_in;
   logic [WALK_W-1:0]           nx_ff, nx_in;
   logic [WALK_W-1:0]           split_ff, split_in;
   logic [WORD_W-1:0]           rest_ff, rest_in;
   logic [WORD_W-1:0]           cur_ff, cur_in;
   logic [BUD_W-1:0]            budget_ff, budget_in;
   logic [IDX_W-1:0]            sentinel_ff, sentinel_in;
   logic [ifla_pkg::OFF_W-1:0]  off_ff, off_in;
   logic [ifla_pkg::ST_W-1:0]   st_ff, st_in;
   logic                        fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0]           fwd_data_ff;

   logic [WORD_W-1:0]  rdata;
   logic [WALK_W-1:0]  step_cur;
   logic [WALK_W-1:0]  sent_ext;
   logic [WALK_W-1:0]  hdr;
   logic               free_bad;
   logic [WALK_W-1:0]  split_c;
   logic [WORD_W-1:0]  rest_c;
   logic [WALK_W-1:0]  off_idx;
   logic [WORD_W-1:0]  sum_c;
   logic [WALK_W-1:0]  sum_nx;
   logic [WORD_W-1:0]  fmt_round;
   logic [WORD_W-1:0]  fmt_sum;
   logic [FMT_W-1:0]   words_raw;
   logic [FMT_W-1:0]   words;
   logic [FMT_W-1:0]   words_m1;
   logic [FMT_W-1:0]   words_m2;

   // End of walk: at or past the sentinel index, off the heap, sentinel word or zero size
   function automatic logic at_end(input logic [WALK_W-1:0] i,
                                   input logic [WORD_W-1:0] v,
                                   input logic [WALK_W-1:0] s);
      return (i >= s) || (i >= WALK_W'(HEAP_WORDS)) ||
             (v == ifla_pkg::SENTINEL_WORD) || (v[WORD_W-1:2] == '0);
   endfunction

   // Read data with forwarding of a same-cycle write
   assign rdata    = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign step_cur = idx_ff + WALK_W'(rdata[WORD_W-1:2]);
   assign sent_ext = WALK_W'(sentinel_ff);

   // Free address decode
   assign hdr      = WALK_W'(word_ff) - WALK_W'(1);
   assign free_bad = (word_ff == '0) || (hdr >= WALK_W'(HEAP_WORDS));

   // Split arithmetic
   assign rest_c  = rdata - need_ff;
   assign split_c = idx_ff + WALK_W'(need_ff[WORD_W-1:2]);
   assign off_idx = idx_ff + WALK_W'(1);

   // Coalesce merge
   assign sum_c  = cur_ff + rdata;
   assign sum_nx = idx_ff + WALK_W'(sum_c[WORD_W-1:2]);

   // Format size, saturated to the even heap depth
   assign fmt_round = ifla_pkg::round8_plus4(heap_bytes);
   assign fmt_sum   = fmt_round + 13'd8;
   assign words_raw = FMT_W'(fmt_sum[WORD_W-1:2]);
   assign words     = (words_raw > FMT_W'(HEAP_CAP)) ? FMT_W'(HEAP_CAP) : words_raw;
   assign words_m1  = words - FMT_W'(1);
   assign words_m2  = words - FMT_W'(2);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      need_in     = need_ff;
      word_in     = word_ff;
      idx_in      = idx_ff;
      nx_in       = nx_ff;
      split_in    = split_ff;
      rest_in     = rest_ff;
      cur_in      = cur_ff;
      budget_in   = budget_ff;
      sentinel_in = sentinel_ff;
      off_in      = off_ff;
      st_in       = st_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[IDX_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[IDX_W-1:0];
      ram_wr_data = rdata;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in    = req_action;
               need_in   = ifla_pkg::round8_plus4(req_length);
               word_in   = req_address[ifla_pkg::OFF_W-1:2];
               idx_in    = WALK_W'(1);
               budget_in = BUD_W'(HEAP_WORDS);
               off_in    = '0;
               st_in     = ifla_pkg::ST_OK;
               state_in  = S_START;
            end
         end

         S_START: begin
            case (act_ff)
               ifla_pkg::ACT_FORMAT: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = IDX_W'(1);
                  ram_wr_data = {words_m2[10:0], 2'b00};
                  state_in    = S_FMT;
               end
               ifla_pkg::ACT_ALLOC: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(1);
                  state_in    = S_ALLOC;
               end
               ifla_pkg::ACT_FREE: begin
                  if (free_bad) begin
                     st_in    = ifla_pkg::ST_ALREADY_FREE;
                     state_in = S_DONE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = hdr[IDX_W-1:0];
                     idx_in      = hdr;
                     state_in    = S_FREE;
                  end
               end
               default: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(1);
                  state_in    = S_CO_HDR;
               end
            endcase
         end

         S_FMT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = words_m1[IDX_W-1:0];
            ram_wr_data = ifla_pkg::SENTINEL_WORD;
            sentinel_in = words_m1[IDX_W-1:0];
            state_in    = S_DONE;
         end

         // First-fit walk, one header per cycle
         S_ALLOC: begin
            if (budget_ff == '0 || at_end(idx_ff, rdata, sent_ext)) begin
               st_in    = ifla_pkg::ST_NO_FIT;
               state_in = S_DONE;
            end else if (!rdata[0] && rdata >= need_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {need_ff[WORD_W-1:3], 3'b001};
               off_in      = {off_idx[9:0], 2'b00};
               split_in    = split_c;
               rest_in     = rest_c;
               if (rest_c != '0 && split_c < WALK_W'(HEAP_WORDS)) begin
                  state_in = S_SPLIT;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               budget_in   = budget_ff - BUD_W'(1);
               idx_in      = step_cur;
               ram_rd_en   = 1'b1;
               ram_rd_addr = step_cur[IDX_W-1:0];
            end
         end

         S_SPLIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = split_ff[IDX_W-1:0];
            ram_wr_data = rest_ff;
            state_in    = S_DONE;
         end

         S_FREE: begin
            if (rdata == ifla_pkg::SENTINEL_WORD || idx_ff == sent_ext) begin
               st_in = ifla_pkg::ST_SENTINEL;
            end else if (!rdata[0]) begin
               st_in = ifla_pkg::ST_ALREADY_FREE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {rdata[WORD_W-1:1], 1'b0};
            end
            state_in = S_DONE;
         end

         // Coalesce: visit a header
         S_CO_HDR: begin
            if (budget_ff == '0 || at_end(idx_ff, rdata, sent_ext)) begin
               state_in = S_DONE;
            end else begin
               budget_in   = budget_ff - BUD_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = step_cur[IDX_W-1:0];
               if (!rdata[0]) begin
                  cur_in   = rdata;
                  nx_in    = step_cur;
                  state_in = S_CO_NX;
               end else begin
                  idx_in = step_cur;
               end
            end
         end

         // Coalesce: absorb following free blocks
         S_CO_NX: begin
            if (budget_ff != '0 && !at_end(nx_ff, rdata, sent_ext) && !rdata[0]) begin
               budget_in   = budget_ff - BUD_W'(1);
               cur_in      = sum_c;
               ram_wr_en   = 1'b1;
               ram_wr_data = sum_c;
               nx_in       = sum_nx;
               ram_rd_en   = 1'b1;
               ram_rd_addr = sum_nx[IDX_W-1:0];
            end else begin
               idx_in      = nx_ff;
               ram_rd_en   = 1'b1;
               ram_rd_addr = nx_ff[IDX_W-1:0];
               state_in    = S_CO_HDR;
            end
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign fwd_hit_in = ram_rd_en && ram_wr_en && (ram_rd_addr == ram_wr_addr);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         sentinel_ff <= IDX_W'(HEAP_WORDS - 1);
         fwd_hit_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sentinel_ff <= sentinel_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      need_ff     <= need_in;
      word_ff     <= word_in;
      idx_ff      <= idx_in;
      nx_ff       <= nx_in;
      split_ff    <= split_in;
      rest_ff     <= rest_in;
      cur_ff      <= cur_in;
      budget_ff   <= budget_in;
      off_ff      <= off_in;
      st_ff       <= st_in;
      fwd_data_ff <= ram_wr_data;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign res.valid          = (state_ff == S_DONE);
   assign res.payload_offset = off_ff;
   assign res.status         = st_ff;

`ifndef NO_ASSERTIONS
   // Same-entry read and write only happens while merging
   a_fwd_only_merge: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && ram_wr_en && ram_rd_addr == ram_wr_addr) |-> state_ff == S_CO_NX)
      else $error("same-entry access outside of merge");

   // Sentinel moves only on format
   a_sentinel_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FMT) |=> $stable(sentinel_ff))
      else $error("sentinel index changed outside format");

   // Visit budget stays within the heap depth
   a_budget_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC || state_ff == S_CO_HDR || state_ff == S_CO_NX)
         |-> budget_ff <= BUD_W'(HEAP_WORDS))
      else $error("walk budget out of range");

   // Split header lands after the block it was cut from
   a_split_after: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT) |-> (split_ff > idx_ff && ram_wr_en))
      else $error("split header not after allocated header");
`endif

endmodule

>>> rtl/implicit_free_list_allocator.sv
// First-fit heap allocator over an implicit free list held in one word memory.
// Request channel (req_valid / req_stall): action, length and address of one item.
//   Format builds one free block plus the end marker from the heap_bytes register,
//   allocate walks the list and splits the first block that fits, free clears the
//   allocated bit of a header, coalesce merges runs of adjacent free blocks.
// Response channel (rsp_valid / rsp_stall): one item per request, payload byte
//   offset and status.
// Config port (csr_*): heap_bytes at byte address 0, to be written by the user only
//   while the block idles; the block itself does not enforce this. One item is in
//   work at a time. The walk visits one header a cycle through the single
//   registered read port of the heap memory.
// A finished item sits in the output register; the next request is taken while it
//   waits. With rsp_stall held the engine keeps its next result and stalls requests.
// Reset clears the control state, sets heap_bytes to 4084 and the end marker index to
//   the last word. Heap contents are undefined until the first format.
module implicit_free_list_allocator #(
   parameter int HEAP_WORDS = ifla_pkg::HEAP_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ifla_pkg::ACT_W-1:0]      req_action,
   input  logic [ifla_pkg::LEN_W-1:0]      req_length,
   input  logic [ifla_pkg::OFF_W-1:0]      req_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ifla_pkg::OFF_W-1:0]      rsp_payload_offset,
   output logic [ifla_pkg::ST_W-1:0]       rsp_status,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ifla_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ifla_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ifla_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W = $clog2(HEAP_WORDS);

   logic [ifla_pkg::OFF_W-1:0]  heap_bytes;
   ifla_pkg::res_type           res;
   logic                        res_take;
   logic                        ram_rd_en;
   logic [IDX_W-1:0]            ram_rd_addr;
   logic [ifla_pkg::WORD_W-1:0] ram_rd_data;
   logic                        ram_wr_en;
   logic [IDX_W-1:0]            ram_wr_addr;
   logic [ifla_pkg::WORD_W-1:0] ram_wr_data;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ifla_pkg::OFF_W-1:0]  rsp_off_ff;
   logic [ifla_pkg::ST_W-1:0]   rsp_st_ff;

   ifla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .heap_bytes  (heap_bytes)
   );

   ifla_heap_ram #(
      .DEPTH (HEAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   ifla_engine #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_length  (req_length),
      .req_address (req_address),
      .heap_bytes  (heap_bytes),
      .res         (res),
      .res_take    (res_take),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   // Output register: load when empty or being drained
   assign res_take = res.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_off_ff <= res.payload_offset;
         rsp_st_ff  <= res.status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_off_ff;
   assign rsp_status         = rsp_st_ff;

endmodule

>>> verif/tb_implicit_free_list_allocator.sv
`timescale 1ns / 1ps

module tb_implicit_free_list_allocator;

   localparam int WORD_W     = ifla_pkg::WORD_W;
   localparam int OFF_W      = ifla_pkg::OFF_W;
   localparam int LEN_W      = ifla_pkg::LEN_W;
   localparam int ACT_W      = ifla_pkg::ACT_W;
   localparam int ST_W       = ifla_pkg::ST_W;
   localparam int CSR_ADDR_W = ifla_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = ifla_pkg::CSR_DATA_W;
   localparam int HEAP_W     = ifla_pkg::HEAP_WORDS_DEF;
   localparam logic [CSR_ADDR_W-1:0] HEAP_BYTES_ADDR =
      CSR_ADDR_W'(4 * ifla_pkg::REG_HEAP_BYTES);

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [LEN_W-1:0] length;
      logic [OFF_W-1:0] address;
   } heap_request_type;

   typedef struct packed {
      logic [OFF_W-1:0] payload_offset;
      logic [ST_W-1:0]  status;
   } alloc_result_type;

   // DUT signals; the inputs are known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ACT_W-1:0]      req_action = ifla_pkg::ACT_FORMAT;
   logic [LEN_W-1:0]      req_length = '0;
   logic [OFF_W-1:0]      req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OFF_W-1:0]      rsp_payload_offset;
   logic [ST_W-1:0]       rsp_status;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow heap and the allocator's own bookkeeping
   logic [WORD_W-1:0] heap_img [HEAP_W] = '{default: '0};
   bit                img_written [HEAP_W] = '{default: 1'b0};
   int unsigned       img_end = HEAP_W - 1;
   logic [OFF_W-1:0]  img_heap_bytes = ifla_pkg::HEAP_BYTES_RESET;

   heap_request_type requests_q [$];
   alloc_result_type results_due [$];
   int unsigned      live_offsets [$];
   heap_request_type next_req;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          drain_first = 1'b0;
   int unsigned mismatches = 0;

   implicit_free_list_allocator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_length         (req_length),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic flag_error(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------
   // Heap shadow
   // ---------------------------------------------------------------

   // A walk stops at the sentinel index, a sentinel word, or a zero size step
   function automatic bit at_list_end(input int unsigned idx);
      if (idx >= img_end || idx >= HEAP_W)
         return 1'b1;
      return heap_img[idx] == ifla_pkg::SENTINEL_WORD || (heap_img[idx] >> 2) == 0;
   endfunction

   function automatic void apply_format();
      int unsigned words;
      words = (((int'(img_heap_bytes) + 4 + 7) & ~7) + 8) >> 2;
      if (words > (HEAP_W & ~1))
         words = HEAP_W & ~1;
      heap_img[1] = WORD_W'((words - 2) * 4);
      heap_img[words - 1] = ifla_pkg::SENTINEL_WORD;
      img_written[1] = 1'b1;
      img_written[words - 1] = 1'b1;
      img_end = words - 1;
   endfunction

   // First fit, split off the remainder when there is one
   function automatic logic [ST_W-1:0] apply_alloc(input logic [LEN_W-1:0] len,
                                                   output logic [OFF_W-1:0] off);
      int unsigned need, idx, rest, split;
      logic [WORD_W-1:0] v;
      off = '0;
      need = (int'(len) + 4 + 7) & ~7;
      idx = 1;
      for (int budget = HEAP_W; budget > 0; budget--) begin
         if (at_list_end(idx))
            return ifla_pkg::ST_NO_FIT;
         v = heap_img[idx];
         if (!v[0] && v >= need) begin
            rest = v - need;
            heap_img[idx] = WORD_W'(need + 1);
            split = idx + (need >> 2);
            if (rest > 0 && split < HEAP_W) begin
               heap_img[split] = WORD_W'(rest);
               img_written[split] = 1'b1;
            end
            off = OFF_W'((idx + 1) * 4);
            return ifla_pkg::ST_OK;
         end
         idx += v >> 2;
      end
      return ifla_pkg::ST_NO_FIT;
   endfunction

   function automatic logic [ST_W-1:0] apply_free(input logic [OFF_W-1:0] adr);
      int unsigned w, hdr;
      logic [WORD_W-1:0] v;
      w = adr >> 2;
      if (w == 0 || w - 1 >= HEAP_W)
         return ifla_pkg::ST_ALREADY_FREE;
      hdr = w - 1;
      v = heap_img[hdr];
      if (v == ifla_pkg::SENTINEL_WORD || hdr == img_end)
         return ifla_pkg::ST_SENTINEL;
      if (!v[0])
         return ifla_pkg::ST_ALREADY_FREE;
      heap_img[hdr] = v & ~WORD_W'(1);
      return ifla_pkg::ST_OK;
   endfunction

   // Merge each run of free blocks into its first block
   function automatic void apply_coalesce();
      int unsigned idx, nx;
      int budget;
      idx = 1;
      budget = HEAP_W;
      while (budget > 0 && !at_list_end(idx)) begin
         budget--;
         if (!heap_img[idx][0]) begin
            nx = idx + (heap_img[idx] >> 2);
            while (budget > 0 && !at_list_end(nx) && !heap_img[nx][0]) begin
               budget--;
               heap_img[idx] = heap_img[idx] + heap_img[nx];
               nx = idx + (heap_img[idx] >> 2);
            end
         end
         idx += heap_img[idx] >> 2;
      end
   endfunction

   // Update the shadow for one accepted item and queue its result
   function automatic void predict_item(input heap_request_type r);
      alloc_result_type res;
      logic [OFF_W-1:0] off;
      int unsigned base;
      res.payload_offset = '0;
      res.status = ifla_pkg::ST_OK;
      case (r.action)
         ifla_pkg::ACT_FORMAT: begin
            apply_format();
            live_offsets.delete();
         end
         ifla_pkg::ACT_ALLOC: begin
            res.status = apply_alloc(r.length, off);
            res.payload_offset = off;
            if (res.status == ifla_pkg::ST_OK)
               live_offsets.push_back(off);
         end
         ifla_pkg::ACT_FREE: begin
            res.status = apply_free(r.address);
            base = {r.address[OFF_W-1:2], 2'b00};
            if (res.status == ifla_pkg::ST_OK) begin
               for (int i = 0; i < live_offsets.size(); i++) begin
                  if (live_offsets[i] == base) begin
                     live_offsets.delete(i);
                     break;
                  end
               end
            end
         end
         default: apply_coalesce();
      endcase
      results_due.push_back(res);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: payload holds while stalled
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_item('{req_action, req_length, req_address});
         if (!req_valid || !req_stall) begin
            if (requests_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_req = requests_q.pop_front();
               req_valid <= 1'b1;
               req_action <= next_req.action;
               req_length <= next_req.length;
               req_address <= next_req.address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor and receiver stall
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               flag_error("result with none outstanding", 32'(rsp_payload_offset), 32'(0));
            end else begin
               want = results_due.pop_front();
               if (rsp_payload_offset !== want.payload_offset)
                  flag_error("payload_offset", 32'(rsp_payload_offset),
                             32'(want.payload_offset));
               if (rsp_status !== want.status)
                  flag_error("status", 32'(rsp_status), 32'(want.status));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic send(input logic [ACT_W-1:0] act, input int unsigned len,
                       input int unsigned adr);
      heap_request_type r;
      @(negedge clock);
      while (requests_q.size() >= 2)
         @(negedge clock);
      // pressure: hold off until the block has handed back everything
      while (drain_first && (requests_q.size() != 0 || req_valid || results_due.size() != 0))
         @(negedge clock);
      r.action = act;
      r.length = LEN_W'(len);
      r.address = OFF_W'(adr);
      requests_q.push_back(r);
   endtask

   // Mostly alloc/free of live blocks; some stray frees, coalesce, reformat
   task automatic send_random();
      int unsigned pick, len, adr, cand;
      logic [ACT_W-1:0] act;
      pick = $urandom_range(99);
      len = $urandom_range(4095);
      adr = $urandom_range(4095);
      if (pick < 4) begin
         act = ifla_pkg::ACT_FORMAT;
      end else if (pick < 50) begin
         act = ifla_pkg::ACT_ALLOC;
         case ($urandom_range(19))
            0:       len = $urandom_range(4095);
            1, 2, 3: len = $urandom_range(1000);
            default: len = $urandom_range(120);
         endcase
      end else if (pick < 88) begin
         act = ifla_pkg::ACT_FREE;
         if (live_offsets.size() != 0 && $urandom_range(99) < 80) begin
            adr = live_offsets[$urandom_range(live_offsets.size() - 1)];
            if ($urandom_range(3) == 0)
               adr = adr | $urandom_range(3);
         end else begin
            // prefer headers that have been written at some point, else an address below 4
            adr = $urandom_range(3);
            for (int t = 0; t < 16; t++) begin
               cand = $urandom_range(4095);
               if (cand >= 4 && img_written[(cand >> 2) - 1]) begin
                  adr = cand;
                  break;
               end
            end
         end
      end else begin
         act = ifla_pkg::ACT_COALESCE;
      end
      send(act, len, adr);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (requests_q.size() != 0 || req_valid || results_due.size() != 0)
         @(negedge clock);
   endtask

   // One APB transfer: setup, then access until pready
   task automatic csr_xfer(input bit wr, input logic [CSR_DATA_W-1:0] wdata,
                           output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= HEAP_BYTES_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_heap_bytes(input int unsigned bytes);
      logic [CSR_DATA_W-1:0] rd;
      wait_idle();
      repeat (4) @(posedge clock);
      csr_xfer(1'b1, CSR_DATA_W'(bytes), rd);
      img_heap_bytes = OFF_W'(bytes);
      csr_xfer(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(img_heap_bytes))
         flag_error("heap_bytes readback", rd, 32'(img_heap_bytes));
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      logic [CSR_DATA_W-1:0] rd;
      int unsigned heap_sizes [8] = '{4084, 300, 4095, 0, 64, 4084, 1500, 0};
      int unsigned phase_idle [4] = '{0, 64, 0, 38};
      int unsigned phase_stall [4] = '{0, 0, 64, 38};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      csr_xfer(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(ifla_pkg::HEAP_BYTES_RESET))
         flag_error("heap_bytes after reset", rd, 32'(ifla_pkg::HEAP_BYTES_RESET));

      // full heap: exact fits, no fit, double free, stray low address bits
      send(ifla_pkg::ACT_FORMAT, 4095, 4095);
      send(ifla_pkg::ACT_ALLOC, 0, 4095);
      send(ifla_pkg::ACT_ALLOC, 4095, 0);
      send(ifla_pkg::ACT_ALLOC, 4076, 4095);
      send(ifla_pkg::ACT_ALLOC, 1, 0);
      send(ifla_pkg::ACT_FREE, 0, 8);
      send(ifla_pkg::ACT_FREE, 4095, 8);
      send(ifla_pkg::ACT_FREE, 0, 19);
      send(ifla_pkg::ACT_FREE, 4095, 0);
      send(ifla_pkg::ACT_FREE, 0, 3);
      send(ifla_pkg::ACT_COALESCE, 4095, 4095);
      send(ifla_pkg::ACT_ALLOC, 4084, 0);
      send(ifla_pkg::ACT_FREE, 0, 8);
      send(ifla_pkg::ACT_COALESCE, 0, 0);

      // smallest heap: one 8-byte block, free of the sentinel index
      set_heap_bytes(0);
      send(ifla_pkg::ACT_FORMAT, 0, 0);
      send(ifla_pkg::ACT_ALLOC, 0, 0);
      send(ifla_pkg::ACT_ALLOC, 0, 0);
      send(ifla_pkg::ACT_FREE, 0, 16);

      // stale sentinel word below the new sentinel index
      set_heap_bytes(100);
      send(ifla_pkg::ACT_FORMAT, 0, 0);
      send(ifla_pkg::ACT_FREE, 0, 16);
      send(ifla_pkg::ACT_ALLOC, 4, 0);

      // oversize heap_bytes saturates the heap
      set_heap_bytes(4095);
      send(ifla_pkg::ACT_FORMAT, 0, 0);
      send(ifla_pkg::ACT_ALLOC, 4095, 0);
      send(ifla_pkg::ACT_COALESCE, 0, 0);

      // random phases across heap sizes, idle and stall patterns
      for (int p = 0; p < 8; p++) begin
         set_heap_bytes(heap_sizes[p] != 0 ? heap_sizes[p] : $urandom_range(4095));
         idle_pct = phase_idle[p % 4];
         stall_pct = phase_stall[p % 4];
         send(ifla_pkg::ACT_FORMAT, $urandom_range(4095), $urandom_range(4095));
         repeat (110) send_random();
      end

      // sender drains the block before every item
      set_heap_bytes(4084);
      idle_pct = 0;
      stall_pct = 38;
      drain_first = 1'b1;
      send(ifla_pkg::ACT_FORMAT, 0, 0);
      repeat (30) send_random();
      drain_first = 1'b0;

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #200_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
